>>> src/spi_ee_pkg.sv
// Shared types and constants for the SPI serial EEPROM slave.
// Depends on nothing; spi_ee_ctrl, spi_ee_mem and spi_eeprom_slave import it.
package spi_ee_pkg;

  localparam int ADDR_W        = 8;
  localparam int ADDR_SPAN     = 1 << ADDR_W;
  localparam int MEM_DEPTH_DEF = 256;

  typedef struct packed {
    logic              rd_en;
    logic              wr_en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        wdata;
  } mem_req_t;

  typedef struct packed {
    logic       use_mem;
    logic [7:0] tx_fixed;
  } result_t;

endpackage

>>> src/spi_ee_req_if.sv
// Request channel of the SPI serial EEPROM slave: one received byte per request.
// Standalone valid/ready interface; depends on nothing.
interface spi_ee_req_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       cs_high;

  modport source (output valid, output rx_byte, output cs_high, input ready);
  modport sink (input valid, input rx_byte, input cs_high, output ready);
endinterface

>>> src/spi_ee_rsp_if.sv
// Result channel of the SPI serial EEPROM slave: one byte for MISO per request.
// Standalone valid/ready interface; depends on nothing.
interface spi_ee_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;

  modport source (output valid, output tx_byte, input ready);
  modport sink (input valid, input tx_byte, output ready);
endinterface

>>> src/spi_ee_ctrl.sv
// Command decoder and transaction state of the SPI serial EEPROM slave.
// Depends on spi_ee_pkg for the memory request and result structs.
module spi_ee_ctrl import spi_ee_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     step,
  input  logic [7:0] rx_byte,
  input  logic     cs_high,
  output mem_req_t mem_req,
  output result_t  result
);

  localparam logic [7:0] OP_READ  = 8'h03;
  localparam logic [7:0] OP_WRITE = 8'h02;
  localparam logic [7:0] OP_WREN  = 8'h06;
  localparam logic [7:0] OP_RDSR  = 8'h05;

  typedef enum logic [4:0] {
    PH_CMD    = 5'b00001,
    PH_ADDR   = 5'b00010,
    PH_READ   = 5'b00100,
    PH_WRITE  = 5'b01000,
    PH_STATUS = 5'b10000
  } phase_t;

  phase_t            phase, phase_next;
  logic [7:0]        cmd_code, cmd_code_next;
  logic [ADDR_W-1:0] mem_addr, mem_addr_next;
  logic              wel, wel_next;
  logic              rd, wr;
  logic [7:0]        status_byte;

  assign status_byte = {6'd0, wel, 1'b0};

  always_comb begin
    phase_next    = phase;
    cmd_code_next = cmd_code;
    mem_addr_next = mem_addr;
    wel_next      = wel;
    rd            = 1'b0;
    wr            = 1'b0;
    mem_req.addr  = mem_addr;
    mem_req.wdata = rx_byte;
    result        = '0;
    if (cs_high) begin
      phase_next    = PH_CMD;
      cmd_code_next = '0;
      mem_addr_next = '0;
    end else begin
      case (phase)
        PH_CMD: begin
          cmd_code_next = rx_byte;
          if (rx_byte == OP_READ || rx_byte == OP_WRITE) begin
            phase_next = PH_ADDR;
          end else if (rx_byte == OP_WREN) begin
            wel_next = 1'b1;
          end else if (rx_byte == OP_RDSR) begin
            phase_next      = PH_STATUS;
            result.tx_fixed = status_byte;
          end
        end
        PH_ADDR: begin
          mem_addr_next = rx_byte;
          if (cmd_code == OP_READ) begin
            phase_next     = PH_READ;
            rd             = 1'b1;
            mem_req.addr   = rx_byte;
            result.use_mem = 1'b1;
            mem_addr_next  = rx_byte + 8'd1;
          end else if (cmd_code == OP_WRITE) begin
            phase_next = PH_WRITE;
          end else begin
            phase_next = PH_CMD;
          end
        end
        PH_READ: begin
          rd             = 1'b1;
          result.use_mem = 1'b1;
          mem_addr_next  = mem_addr + 8'd1;
        end
        PH_WRITE: begin
          if (wel) begin
            wr            = 1'b1;
            mem_addr_next = mem_addr + 8'd1;
          end
        end
        PH_STATUS: begin
          result.tx_fixed = status_byte;
        end
        default: begin
          phase_next    = PH_CMD;
          cmd_code_next = '0;
          mem_addr_next = '0;
        end
      endcase
    end
    mem_req.rd_en = step && rd;
    mem_req.wr_en = step && wr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_CMD;
      cmd_code <= '0;
      mem_addr <= '0;
      wel      <= 1'b0;
    end else if (step) begin
      phase    <= phase_next;
      cmd_code <= cmd_code_next;
      mem_addr <= mem_addr_next;
      wel      <= wel_next;
    end
  end

endmodule

>>> src/spi_ee_mem.sv
// Byte store of the SPI serial EEPROM slave: one write and one registered read port,
// with per-entry valid bits so unwritten entries read as zero. Depends on spi_ee_pkg.
module spi_ee_mem import spi_ee_pkg::*; #(
  parameter int MEM_DEPTH = MEM_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  mem_req_t   mem_req,
  output logic [7:0] rd_byte
);

  localparam int StoreDepth = (MEM_DEPTH < ADDR_SPAN) ? MEM_DEPTH : ADDR_SPAN;
  localparam int IdxW       = $clog2(StoreDepth);

  logic [IdxW-1:0]       idx_tbl [ADDR_SPAN];
  logic [IdxW-1:0]       idx;
  logic [StoreDepth-1:0] valid;
  logic [7:0]            mem [StoreDepth];
  logic [7:0]            rd_data;
  logic                  rd_valid;

  for (genvar a = 0; a < ADDR_SPAN; a++) begin : g_idx
    assign idx_tbl[a] = IdxW'(a % StoreDepth);
  end

  assign idx = idx_tbl[mem_req.addr];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (mem_req.wr_en) begin
      valid[idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_req.wr_en) begin
      mem[idx] <= mem_req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_req.rd_en) begin
      rd_data  <= mem[idx];
      rd_valid <= valid[idx];
    end
  end

  assign rd_byte = rd_valid ? rd_data : 8'd0;

endmodule

>>> src/spi_eeprom_slave.sv
// Slave side of a 25xx-style SPI serial EEPROM, one completed SPI byte per request.
// Takes a request every clock cycle while the result is not stalled; the result passes
// through the input register, then the result register with the memory's registered
// read port, and a stalled result holds the input register so nothing is dropped.
// The store has per-entry valid bits cleared at reset, so there is no clearing pass.
// Depends on spi_ee_pkg, spi_ee_req_if, spi_ee_rsp_if, spi_ee_ctrl and spi_ee_mem.
module spi_eeprom_slave import spi_ee_pkg::*; #(
  parameter int MEM_DEPTH = MEM_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  spi_ee_req_if.sink   req,
  spi_ee_rsp_if.source rsp
);

  logic       s1_valid;
  logic [7:0] s1_rx;
  logic       s1_cs;
  logic       s2_valid;
  result_t    res_q;
  logic       s2_free;
  logic       fire;
  mem_req_t   mem_req;
  result_t    result;
  logic [7:0] rd_byte;

  assign s2_free   = !s2_valid || rsp.ready;
  assign fire      = s1_valid && s2_free;
  assign req.ready = !s1_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (req.ready) begin
        s1_valid <= req.valid;
      end
      if (s2_free) begin
        s2_valid <= fire;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1_rx <= req.rx_byte;
      s1_cs <= req.cs_high;
    end
    if (fire) begin
      res_q <= result;
    end
  end

  spi_ee_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .step    (fire),
    .rx_byte (s1_rx),
    .cs_high (s1_cs),
    .mem_req (mem_req),
    .result  (result)
  );

  spi_ee_mem #(
    .MEM_DEPTH (MEM_DEPTH)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .mem_req (mem_req),
    .rd_byte (rd_byte)
  );

  assign rsp.valid   = s2_valid;
  assign rsp.tx_byte = res_q.use_mem ? rd_byte : res_q.tx_fixed;

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !s2_valid |-> req.ready)
    else $error("request not taken while result stage empty");

  a_cs_gives_zero: assert property (@(posedge clk) disable iff (rst)
    fire && s1_cs |=> rsp.valid && rsp.tx_byte == 8'h00)
    else $error("chip select high did not return zero");

  a_no_rd_wr_clash: assert property (@(posedge clk) disable iff (rst)
    !(mem_req.rd_en && mem_req.wr_en))
    else $error("memory read and write in the same cycle");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s2_valid && !rsp.ready |=> s1_valid && $stable(s1_rx))
    else $error("input stage lost a request during stall");

endmodule
